@@ rtl/lkvc_pkg.sv @@
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;
  localparam int ENTRIES_DEF = 16;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CAP_W-1:0]         cap_t;

  // operation codes carried in the kind field
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam cap_t  CAP_RESET  = CAP_W'(16);
  localparam data_t MISS_VALUE = '1;

  typedef struct packed {
    logic  kind;
    data_t key;
    data_t value;
  } req_t;

  typedef struct packed {
    logic  found;
    data_t read_value;
    logic  evicted;
    data_t evicted_key;
  } rsp_t;

  // table update command for one item
  typedef struct packed {
    logic en;      // commit this item to the table
    logic hit;     // key already present: touch, write value on a put
    logic is_put;  // write the value
    logic evict;   // insert reuses the victim slot, occupancy holds
  } upd_t;

endpackage

@@ rtl/lkvc_if.sv @@
`timescale 1ns / 1ps

interface lkvc_req_if import lkvc_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  kind;
  data_t key;
  data_t value;

  modport source(output valid, kind, key, value, input ready);
  modport sink(input valid, kind, key, value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  found;
  data_t read_value;
  logic  evicted;
  data_t evicted_key;

  modport source(output valid, found, read_value, evicted, evicted_key, input ready);
  modport sink(input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

@@ rtl/lkvc_match.sv @@
`timescale 1ns / 1ps

module lkvc_match import lkvc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  data_t              keys  [ENTRIES],
  input  logic               valid [ENTRIES],
  input  logic [IDX_W-1:0]   ranks [ENTRIES],
  input  logic [CNT_W-1:0]   count,
  input  data_t              key,
  output logic               hit,
  output logic [IDX_W-1:0]   hit_idx,
  output logic [IDX_W-1:0]   free_idx,
  output logic [IDX_W-1:0]   victim_idx
);

  logic [CNT_W-1:0] oldest_rank;

  assign oldest_rank = count - CNT_W'(1);

  // Keys of valid entries are unique and ranks of valid entries form
  // 0..count-1, so the hit and victim matches are at most one-hot.
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i] && keys[i] == key) begin
        hit     = 1'b1;
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (valid[i] && CNT_W'(ranks[i]) == oldest_rank) begin
        victim_idx = victim_idx | IDX_W'(i);
      end
    end
    // lowest free slot wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

endmodule

@@ rtl/lkvc_table.sv @@
`timescale 1ns / 1ps

module lkvc_table import lkvc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  upd_t              upd,
  input  logic [IDX_W-1:0]  slot,
  input  data_t             key,
  input  data_t             value,
  output data_t             keys  [ENTRIES],
  output data_t             values[ENTRIES],
  output logic              valid [ENTRIES],
  output logic [IDX_W-1:0]  ranks [ENTRIES],
  output logic [CNT_W-1:0]  count
);

  logic [IDX_W-1:0] slot_rank;

  assign slot_rank = ranks[slot];

  // key and value storage, no reset
  always_ff @(posedge clk) begin
    if (upd.en) begin
      if (!upd.hit) begin
        keys[slot] <= key;
      end
      if (upd.is_put) begin
        values[slot] <= value;
      end
    end
  end

  // valid bits, recency ranks and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
        ranks[i] <= '0;
      end
    end else if (upd.en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          ranks[i] <= '0;
          valid[i] <= 1'b1;
        end else if (valid[i] && (!upd.hit || ranks[i] < slot_rank)) begin
          ranks[i] <= ranks[i] + IDX_W'(1);
        end
      end
      if (!upd.hit && !upd.evict) begin
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/lru_key_value_cache_core.sv @@
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// Each request item is a get or a put of a signed 32-bit key; every item
// returns exactly one response item in order. The block takes one item per
// clock cycle while the response is not stalled. Each item passes the
// request register, where the key is matched against all ENTRIES keys at
// once and the recency ranks are updated in the same cycle, then the
// response register. That parallel match and rank update sets the rate.
// A stalled response holds the request register, and a new item is taken
// whenever the request register moves on or is empty.
// The capacity register (cfg_wr_data, 0 meaning 1, values above ENTRIES
// meaning ENTRIES) is written only while the table is empty; a write that
// arrives while entries are held is dropped. Reset empties the table and
// sets the capacity to 16; no clearing pass is needed.
module lru_key_value_cache_core import lkvc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  cap_t       cfg_wr_data,
  lkvc_req_if.sink   req,
  lkvc_rsp_if.source rsp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // request register
  logic stage_valid;
  req_t stage_req;
  logic advance;

  // response register
  logic rsp_valid;
  rsp_t rsp_data;
  rsp_t rsp_next;

  // capacity register and its effective value
  cap_t             capacity;
  logic [CNT_W-1:0] cap_eff;

  // table view
  data_t            keys  [ENTRIES];
  data_t            values[ENTRIES];
  logic             valid [ENTRIES];
  logic [IDX_W-1:0] ranks [ENTRIES];
  logic [CNT_W-1:0] count;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] victim_idx;
  logic [IDX_W-1:0] slot;
  logic             is_put;
  logic             evict;
  upd_t             upd;

  // Move the held item on when the response register is free or drains.
  assign advance   = stage_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_req <= '{kind: req.kind, key: req.key, value: req.value};
    end
  end

  // Capacity changes only while the table is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en && count == '0) begin
      capacity <= cfg_wr_data;
    end
  end

  // Clamp zero up to one and large values down to the table depth.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity) > 32'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  lkvc_match #(
    .ENTRIES(ENTRIES)
  ) u_match (
    .keys      (keys),
    .valid     (valid),
    .ranks     (ranks),
    .count     (count),
    .key       (stage_req.key),
    .hit       (hit),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx),
    .victim_idx(victim_idx)
  );

  // A put of a new key evicts once the table holds the capacity's worth.
  assign is_put = (stage_req.kind == KIND_PUT);
  assign evict  = is_put && !hit && !(count < cap_eff);

  always_comb begin
    if (hit) begin
      slot = hit_idx;
    end else if (evict) begin
      slot = victim_idx;
    end else begin
      slot = free_idx;
    end
  end

  // A get miss leaves the table untouched.
  assign upd = '{en: advance && (hit || is_put), hit: hit, is_put: is_put, evict: evict};

  lkvc_table #(
    .ENTRIES(ENTRIES)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .upd   (upd),
    .slot  (slot),
    .key   (stage_req.key),
    .value (stage_req.value),
    .keys  (keys),
    .values(values),
    .valid (valid),
    .ranks (ranks),
    .count (count)
  );

  // Build the response from the table as it stands before this item.
  always_comb begin
    rsp_next.found       = hit;
    rsp_next.evicted     = evict;
    rsp_next.evicted_key = evict ? keys[victim_idx] : '0;
    if (is_put) begin
      rsp_next.read_value = '0;
    end else if (hit) begin
      rsp_next.read_value = values[hit_idx];
    end else begin
      rsp_next.read_value = MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= rsp_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.found       = rsp_data.found;
  assign rsp.read_value  = rsp_data.read_value;
  assign rsp.evicted     = rsp_data.evicted;
  assign rsp.evicted_key = rsp_data.evicted_key;

endmodule
